// ----- hdl/pbra_pkg.sv -----
package pbra_pkg;

   localparam int MAX_PAGES = 4096;
   localparam int WORD_BITS = 64;
   localparam int MAP_WORDS = MAX_PAGES / WORD_BITS;
   localparam int WI_W      = $clog2(MAP_WORDS);
   localparam int PAGE_W    = 12;
   localparam int COUNT_W   = 13;

   // largest page limit: a page number has PAGE_W bits
   localparam logic [COUNT_W-1:0] LIMIT_CAP = COUNT_W'(MAX_PAGES);

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   typedef struct packed {
      logic                operation;
      logic [PAGE_W-1:0]   start_page;
      logic [COUNT_W-1:0]  run_length;
   } req_type;

   typedef struct packed {
      logic                success;
      logic [PAGE_W-1:0]   first_page;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MARK,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic [WORD_BITS-1:0] word;
      logic [WI_W-1:0]      word_index;
      logic [COUNT_W-1:0]   seg_lo;
      logic [COUNT_W-1:0]   seg_hi;
      logic [COUNT_W-1:0]   run;
      logic [COUNT_W-1:0]   count;
   } scan_in_type;

   typedef struct packed {
      logic                 hit;
      logic [5:0]           pos;
      logic [COUNT_W-1:0]   run_out;
   } scan_out_type;

   // bits of map word wi whose page lies in [lo, hi)
   function automatic logic [WORD_BITS-1:0] range_mask(logic [WI_W-1:0] wi,
                                                       logic [COUNT_W-1:0] lo,
                                                       logic [COUNT_W-1:0] hi);
      logic [WORD_BITS-1:0] m;
      logic [COUNT_W-1:0]   page;
      for (int k = 0; k < WORD_BITS; k++) begin
         page = {1'b0, wi, 6'(k)};
         m[k] = (page >= lo) && (page < hi);
      end
      return m;
   endfunction

endpackage

// ----- hdl/pbra_word_scan.sv -----
// One map word per use: finds the first page where the free run reaches
// count, taking the run carried in from lower words into account.
module pbra_word_scan (
   input  pbra_pkg::scan_in_type  scan_in,
   output pbra_pkg::scan_out_type scan_out
);

   logic [63:0] e;
   logic [6:0]  low_ones;
   logic [6:0]  top_ones;
   logic        low_open;
   logic        top_open;
   logic [12:0] need;
   logic [12:0] need_m1;
   logic        prefix_hit;
   logic        short_run;
   logic [6:0]  c;
   logic [2:0]  m;
   logic [6:0]  d;
   logic [63:0] b_mask [7];
   logic [63:0] run_hits;
   logic [5:0]  pos_int;

   always_comb begin
      e = scan_in.word & pbra_pkg::range_mask(scan_in.word_index, scan_in.seg_lo,
                                               scan_in.seg_hi);

      low_ones = 7'd0;
      low_open = 1'b1;
      for (int k = 0; k < 64; k++) begin
         if (low_open && e[k]) begin
            low_ones = low_ones + 7'd1;
         end else begin
            low_open = 1'b0;
         end
      end

      top_ones = 7'd0;
      top_open = 1'b1;
      for (int k = 63; k >= 0; k--) begin
         if (top_open && e[k]) begin
            top_ones = top_ones + 7'd1;
         end else begin
            top_open = 1'b0;
         end
      end

      // run continuing from below completes inside the low ones
      need       = scan_in.count - scan_in.run;
      need_m1    = need - 13'd1;
      prefix_hit = need <= {6'd0, low_ones};

      // b_mask[j][i]: 2**j ones ending at bit i
      b_mask[0] = e;
      for (int j = 1; j < 7; j++) begin
         b_mask[j] = b_mask[j-1] & (b_mask[j-1] << (1 << (j - 1)));
      end

      short_run = scan_in.count <= 13'd64;
      c         = scan_in.count[6:0];
      m         = 3'd0;
      for (int j = 0; j < 7; j++) begin
         if (c[j]) begin
            m = 3'(j);
         end
      end
      d        = c - (7'd1 << m);
      run_hits = short_run ? (b_mask[m] & (b_mask[m] << d)) : 64'd0;

      pos_int = 6'd0;
      for (int k = 63; k >= 0; k--) begin
         if (run_hits[k]) begin
            pos_int = 6'(k);
         end
      end

      scan_out.hit     = prefix_hit || (|run_hits);
      scan_out.pos     = prefix_hit ? need_m1[5:0] : pos_int;
      scan_out.run_out = (&e) ? (scan_in.run + 13'd64) : {6'd0, top_ones};
   end

endmodule

// ----- hdl/page_bitmap_run_allocator.sv -----
// Next-fit allocator of contiguous page runs over a one-bit-per-page map.
// req_* carries one beat per request: allocate (run_length pages) or free
// (run_length pages from start_page). rsp_* returns one beat per request:
// success and, for a successful allocate, the first page of the run.
// csr_wr_en/csr_wr_data set the number of managed pages; write it only
// while no request is in flight.
// Timing: the map is a 64 x 64-bit memory with a registered read port and
// one word is visited per cycle. An allocate is accepted, then scans words
// (up to 65: the origin word can be seen on both passes), marks each word
// the found run touches, and posts the beat. A free marks each word it
// touches and then posts the beat. A zero count, zero limit or empty free
// goes straight to posting the beat.
// req_stall is high from acceptance until the response is posted to the
// output register; a new request is taken while that beat waits under
// rsp_stall, and the next response waits until the register drains.
// Reset: every page used, pointer at page 0, 4096 managed pages, no beat
// pending.
module page_bitmap_run_allocator (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  pbra_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output pbra_pkg::rsp_type               rsp_data,
   input  logic                            csr_wr_en,
   input  logic [pbra_pkg::COUNT_W-1:0]    csr_wr_data
);

   localparam int WI_W = pbra_pkg::WI_W;
   localparam int CW   = pbra_pkg::COUNT_W;
   localparam int PW   = pbra_pkg::PAGE_W;

   pbra_pkg::state_type state_ff, state_in;

   logic [CW-1:0]   managed_ff;
   logic [CW-1:0]   search_start_ff, search_start_in;
   logic            op_ff, op_in;
   logic [CW-1:0]   count_ff, count_in;
   logic [CW-1:0]   seg_lo_ff, seg_lo_in;
   logic [CW-1:0]   seg_hi_ff, seg_hi_in;
   logic [WI_W-1:0] wi_ff, wi_in;
   logic [WI_W-1:0] last_wi_ff, last_wi_in;
   logic [CW-1:0]   run_ff, run_in;
   logic            pass1_ff, pass1_in;
   logic [PW-1:0]   origin_ff, origin_in;
   logic            res_success_ff, res_success_in;
   logic [PW-1:0]   res_first_ff, res_first_in;
   logic            rsp_valid_ff, rsp_valid_in;
   pbra_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic [63:0]     map_mem [pbra_pkg::MAP_WORDS];
   logic [pbra_pkg::MAP_WORDS-1:0] word_valid_ff;
   logic [63:0]     rd_data_ff;
   logic            rd_valid_ff;
   logic [WI_W-1:0] rd_addr;
   logic            wr_en;
   logic [63:0]     wr_data;
   logic [63:0]     cur_word;

   logic [CW-1:0]   lim;
   logic [PW-1:0]   origin;
   logic            req_accept;
   logic [CW:0]     free_sum;
   logic [CW-1:0]   free_end;
   logic [CW-1:0]   free_end_m1;
   logic            free_empty;
   logic            alloc_fail_now;
   logic [CW-1:0]   lim_m1;
   logic [PW-1:0]   origin_ff_m1;
   logic [CW-1:0]   hit_end;
   logic [CW-1:0]   hit_base;
   logic            seg_done;
   logic            go_pass1;
   logic            rsp_free;
   logic            rsp_load;

   pbra_pkg::scan_in_type  scan_in;
   pbra_pkg::scan_out_type scan_out;

   pbra_word_scan u_scan (
      .scan_in  (scan_in),
      .scan_out (scan_out)
   );

   assign lim        = (managed_ff > pbra_pkg::LIMIT_CAP) ? pbra_pkg::LIMIT_CAP : managed_ff;
   assign origin     = (search_start_ff < lim) ? search_start_ff[PW-1:0] : '0;
   assign req_stall  = (state_ff != pbra_pkg::ST_IDLE);
   assign req_accept = req_valid && !req_stall;

   assign free_sum    = {2'b00, req_data.start_page} + {1'b0, req_data.run_length};
   assign free_end    = (free_sum > {1'b0, lim}) ? lim : free_sum[CW-1:0];
   assign free_end_m1 = free_end - 13'd1;
   assign free_empty  = {1'b0, req_data.start_page} >= free_end;
   assign alloc_fail_now = (req_data.run_length == '0) || (lim == '0);
   assign lim_m1       = lim - 13'd1;
   assign origin_ff_m1 = origin_ff - 12'd1;

   // unwritten words still hold their reset value: all pages used
   assign cur_word = rd_valid_ff ? rd_data_ff : '0;

   assign scan_in.word       = cur_word;
   assign scan_in.word_index = wi_ff;
   assign scan_in.seg_lo     = seg_lo_ff;
   assign scan_in.seg_hi     = seg_hi_ff;
   assign scan_in.run        = run_ff;
   assign scan_in.count      = count_ff;

   assign hit_end  = {1'b0, wi_ff, scan_out.pos} + 13'd1;
   assign hit_base = hit_end - count_ff;
   assign seg_done = (wi_ff == last_wi_ff);
   assign go_pass1 = !pass1_ff && (origin_ff != '0);
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pbra_pkg::ST_IDLE: begin
            if (req_accept) begin
               if (req_data.operation == pbra_pkg::OP_FREE) begin
                  state_in = free_empty ? pbra_pkg::ST_RESP : pbra_pkg::ST_MARK;
               end else begin
                  state_in = alloc_fail_now ? pbra_pkg::ST_RESP : pbra_pkg::ST_SCAN;
               end
            end
         end
         pbra_pkg::ST_SCAN: begin
            if (scan_out.hit) begin
               state_in = pbra_pkg::ST_MARK;
            end else if (seg_done && !go_pass1) begin
               state_in = pbra_pkg::ST_RESP;
            end
         end
         pbra_pkg::ST_MARK: begin
            if (seg_done) begin
               state_in = pbra_pkg::ST_RESP;
            end
         end
         pbra_pkg::ST_RESP: begin
            if (rsp_free) begin
               state_in = pbra_pkg::ST_IDLE;
            end
         end
         default: state_in = pbra_pkg::ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      search_start_in = search_start_ff;
      op_in           = op_ff;
      count_in        = count_ff;
      seg_lo_in       = seg_lo_ff;
      seg_hi_in       = seg_hi_ff;
      wi_in           = wi_ff;
      last_wi_in      = last_wi_ff;
      run_in          = run_ff;
      pass1_in        = pass1_ff;
      origin_in       = origin_ff;
      res_success_in  = res_success_ff;
      res_first_in    = res_first_ff;
      rd_addr         = wi_ff;
      wr_en           = 1'b0;
      wr_data         = cur_word;
      rsp_load        = 1'b0;
      case (state_ff)
         pbra_pkg::ST_IDLE: begin
            if (req_accept) begin
               op_in        = req_data.operation;
               count_in     = req_data.run_length;
               origin_in    = origin;
               pass1_in     = 1'b0;
               run_in       = '0;
               res_first_in = '0;
               if (req_data.operation == pbra_pkg::OP_FREE) begin
                  res_success_in = 1'b1;
                  seg_lo_in      = {1'b0, req_data.start_page};
                  seg_hi_in      = free_end;
                  wi_in          = req_data.start_page[PW-1:6];
                  last_wi_in     = free_end_m1[PW-1:6];
                  rd_addr        = req_data.start_page[PW-1:6];
               end else begin
                  res_success_in = 1'b0;
                  seg_lo_in      = {1'b0, origin};
                  seg_hi_in      = lim;
                  wi_in          = origin[PW-1:6];
                  last_wi_in     = lim_m1[PW-1:6];
                  rd_addr        = origin[PW-1:6];
               end
            end
         end
         pbra_pkg::ST_SCAN: begin
            if (scan_out.hit) begin
               res_success_in  = 1'b1;
               res_first_in    = hit_base[PW-1:0];
               search_start_in = hit_end;
               seg_lo_in       = hit_base;
               seg_hi_in       = hit_end;
               wi_in           = hit_base[PW-1:6];
               last_wi_in      = wi_ff;
               rd_addr         = hit_base[PW-1:6];
            end else if (seg_done) begin
               if (go_pass1) begin
                  // second pass: page 0 up to the origin, fresh run
                  pass1_in   = 1'b1;
                  seg_lo_in  = '0;
                  seg_hi_in  = {1'b0, origin_ff};
                  wi_in      = '0;
                  last_wi_in = origin_ff_m1[PW-1:6];
                  run_in     = '0;
                  rd_addr    = '0;
               end
            end else begin
               wi_in   = wi_ff + 6'd1;
               run_in  = scan_out.run_out;
               rd_addr = wi_ff + 6'd1;
            end
         end
         pbra_pkg::ST_MARK: begin
            wr_en = 1'b1;
            if (op_ff == pbra_pkg::OP_FREE) begin
               wr_data = cur_word | pbra_pkg::range_mask(wi_ff, seg_lo_ff, seg_hi_ff);
            end else begin
               wr_data = cur_word & ~pbra_pkg::range_mask(wi_ff, seg_lo_ff, seg_hi_ff);
            end
            wi_in   = wi_ff + 6'd1;
            rd_addr = wi_ff + 6'd1;
         end
         pbra_pkg::ST_RESP: begin
            rsp_load = rsp_free;
         end
         default: begin
            rsp_load = 1'b0;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);
   assign rsp_data_in  = rsp_load ? pbra_pkg::rsp_type'{success: res_success_ff,
                                                        first_page: res_first_ff}
                                  : rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= pbra_pkg::ST_IDLE;
         managed_ff      <= pbra_pkg::LIMIT_CAP;
         search_start_ff <= '0;
         rsp_valid_ff    <= 1'b0;
         word_valid_ff   <= '0;
         rd_valid_ff     <= 1'b0;
      end else begin
         state_ff        <= state_in;
         search_start_ff <= search_start_in;
         rsp_valid_ff    <= rsp_valid_in;
         rd_valid_ff     <= word_valid_ff[rd_addr];
         if (csr_wr_en) begin
            managed_ff <= csr_wr_data;
         end
         if (wr_en) begin
            word_valid_ff[wi_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      count_ff       <= count_in;
      seg_lo_ff      <= seg_lo_in;
      seg_hi_ff      <= seg_hi_in;
      wi_ff          <= wi_in;
      last_wi_ff     <= last_wi_in;
      run_ff         <= run_in;
      pass1_ff       <= pass1_in;
      origin_ff      <= origin_in;
      res_success_ff <= res_success_in;
      res_first_ff   <= res_first_in;
      rsp_data_ff    <= rsp_data_in;
   end

   // free map: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         map_mem[wi_ff] <= wr_data;
      end
      rd_data_ff <= map_mem[rd_addr];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // carried run never reaches the count without a hit
   a_run_below_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pbra_pkg::ST_SCAN) |-> (run_ff < count_ff))
      else $error("scan run reached count without a hit");

   a_mark_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pbra_pkg::ST_MARK) |-> (wi_ff <= last_wi_ff))
      else $error("marking ran past the last word of the run");

   a_pointer_after_run: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pbra_pkg::ST_RESP && op_ff == pbra_pkg::OP_ALLOC && res_success_ff)
      |-> (search_start_ff == 13'({1'b0, res_first_ff} + count_ff)))
      else $error("next-fit pointer not just past the allocated run");

endmodule

// ----- dv/page_bitmap_run_allocator_tb.sv -----
module page_bitmap_run_allocator_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int COUNT_W   = pbra_pkg::COUNT_W;
   localparam int PAGE_W    = pbra_pkg::PAGE_W;
   localparam int MAX_PAGES = pbra_pkg::MAX_PAGES;

   localparam int unsigned CYCLE_LIMIT = 1000000;
   localparam int          HOLD_AT     = 150;
   localparam int          HOLD_CYCLES = 600;
   localparam int          TAIL_CYCLES = 300;
   localparam int          NUM_PHASES  = 7;

   localparam logic [COUNT_W-1:0] PHASE_PAGES [NUM_PHASES] =
      '{13'd4096, 13'd1, 13'd100, 13'd8191, 13'd0, 13'd2000, 13'd4096};
   localparam int PHASE_ITEMS [NUM_PHASES] = '{300, 40, 100, 200, 30, 150, 80};
   localparam int STEADY_PHASE = 3;

   logic               clock;
   logic               reset       = 1'b1;
   logic               req_valid   = 1'b0;
   logic               req_stall;
   pbra_pkg::req_type  req_data    = '0;
   logic               rsp_valid;
   logic               rsp_stall   = 1'b0;
   pbra_pkg::rsp_type  rsp_data;
   logic               csr_wr_en   = 1'b0;
   logic [COUNT_W-1:0] csr_wr_data = '0;

   // predictor state
   bit                 page_free [MAX_PAGES];
   logic [COUNT_W-1:0] alloc_cursor  = '0;
   logic [COUNT_W-1:0] managed_count = 13'd4096;

   pbra_pkg::req_type reqs_waiting [$];
   pbra_pkg::rsp_type outcomes_due [$];
   int          reqs_queued   = 0;
   int          reqs_taken    = 0;
   int          mismatches    = 0;
   int unsigned cycles        = 0;
   logic        req_took      = 1'b0;
   logic        steady        = 1'b0;
   int          hold_left     = 0;
   logic        hold_done     = 1'b0;

   page_bitmap_run_allocator dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   task automatic flag_mismatch(string msg);
      $display("mismatch at cycle %0d: %s", cycles, msg);
      mismatches++;
   endtask

   // applies a free, or a next-fit search over the page map; updates map and cursor
   function automatic pbra_pkg::rsp_type run_outcome(pbra_pkg::req_type r);
      pbra_pkg::rsp_type o;
      int      lim, stop, origin, p, q, left, base;
      o = '0;
      lim = (managed_count > MAX_PAGES) ? MAX_PAGES : int'(managed_count);
      if (r.operation == pbra_pkg::OP_FREE) begin
         stop = int'(r.start_page) + int'(r.run_length);
         if (stop > lim) stop = lim;
         for (p = int'(r.start_page); p < stop; p++) page_free[p] = 1'b1;
         o.success = 1'b1;
         return o;
      end
      if (r.run_length == 0 || lim == 0) return o;
      origin = (int'(alloc_cursor) < lim) ? int'(alloc_cursor) : 0;
      p = origin;
      left = int'(r.run_length);
      do begin
         if (page_free[p]) begin
            left--;
            if (left == 0) begin
               base = p + 1 - int'(r.run_length);
               for (q = base; q <= p; q++) page_free[q] = 1'b0;
               alloc_cursor = COUNT_W'(base + int'(r.run_length));
               o.success = 1'b1;
               o.first_page = PAGE_W'(base);
               return o;
            end
         end else begin
            left = int'(r.run_length);
         end
         p++;
         // a run never spans the wrap
         if (p >= lim) begin
            p = 0;
            left = int'(r.run_length);
         end
      end while (p != origin);
      return o;
   endfunction

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_took) begin
         if (reqs_waiting.size() > 0 && (steady || $urandom_range(0, 99) >= 34)) begin
            req_valid <= 1'b1;
            req_data  <= reqs_waiting.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response backpressure, with one long hold-off
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (!hold_done && reqs_taken >= HOLD_AT) begin
         rsp_stall <= 1'b1;
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else begin
         rsp_stall <= !steady && ($urandom_range(0, 99) < 34);
      end
   end

   // monitor: predict on request beats, check response beats
   always @(posedge clock) begin
      pbra_pkg::rsp_type want;
      req_took <= !reset && req_valid && !req_stall;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (outcomes_due.size() == 0) begin
            flag_mismatch($sformatf("response beat with none pending (success %0b page %0d)",
                                    rsp_data.success, rsp_data.first_page));
         end else begin
            want = outcomes_due.pop_front();
            if (rsp_data.success !== want.success)
               flag_mismatch($sformatf("success got %b want %b",
                                       rsp_data.success, want.success));
            if (rsp_data.first_page !== want.first_page)
               flag_mismatch($sformatf("first_page got %0d want %0d",
                                       rsp_data.first_page, want.first_page));
         end
      end
      if (!reset && req_valid && !req_stall) begin
         outcomes_due.push_back(run_outcome(req_data));
         reqs_taken++;
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic queue_req(logic op, int start, int len);
      pbra_pkg::req_type r;
      r.operation  = op;
      r.start_page = PAGE_W'(start);
      r.run_length = COUNT_W'(len);
      reqs_waiting.push_back(r);
      reqs_queued++;
   endtask

   function automatic pbra_pkg::req_type random_req(int span);
      pbra_pkg::req_type r;
      int      pick;
      pick = $urandom_range(0, 99);
      r.operation  = ($urandom_range(0, 99) < 45) ? pbra_pkg::OP_FREE : pbra_pkg::OP_ALLOC;
      // keep half the frees inside the managed range so they matter
      r.start_page = ($urandom_range(0, 1) == 0) ? PAGE_W'($urandom_range(0, span - 1))
                                                 : PAGE_W'($urandom_range(0, MAX_PAGES - 1));
      if (pick < 65)      r.run_length = COUNT_W'($urandom_range(1, 16));
      else if (pick < 88) r.run_length = COUNT_W'($urandom_range(17, 300));
      else if (pick < 96) r.run_length = COUNT_W'($urandom_range(301, 4096));
      else if (pick < 98) r.run_length = COUNT_W'($urandom_range(4097, 8191));
      else                r.run_length = '0;
      return r;
   endfunction

   task automatic wait_drained();
      while (reqs_taken != reqs_queued || outcomes_due.size() != 0) @(negedge clock);
   endtask

   task automatic write_page_count(logic [COUNT_W-1:0] pages);
      @(negedge clock);
      csr_wr_en     <= 1'b1;
      csr_wr_data   <= pages;
      managed_count  = pages;
      @(negedge clock);
      csr_wr_en     <= 1'b0;
   endtask

   initial begin
      int span;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // map is all used out of reset
      queue_req(pbra_pkg::OP_ALLOC, 4095, 1);
      queue_req(pbra_pkg::OP_ALLOC, 0, 0);
      queue_req(pbra_pkg::OP_FREE, 0, 0);
      queue_req(pbra_pkg::OP_FREE, 0, 4096);
      queue_req(pbra_pkg::OP_ALLOC, 0, 4096);
      queue_req(pbra_pkg::OP_ALLOC, 0, 1);
      queue_req(pbra_pkg::OP_FREE, 4095, 8191);
      queue_req(pbra_pkg::OP_ALLOC, 0, 1);
      queue_req(pbra_pkg::OP_FREE, 4000, 96);
      queue_req(pbra_pkg::OP_FREE, 0, 64);
      queue_req(pbra_pkg::OP_ALLOC, 0, 8191);
      queue_req(pbra_pkg::OP_ALLOC, 0, 4097);
      queue_req(pbra_pkg::OP_ALLOC, 0, 64);
      queue_req(pbra_pkg::OP_ALLOC, 0, 50);
      queue_req(pbra_pkg::OP_ALLOC, 0, 50);
      queue_req(pbra_pkg::OP_ALLOC, 4095, 46);
      // run across a word boundary
      queue_req(pbra_pkg::OP_FREE, 63, 2);
      queue_req(pbra_pkg::OP_ALLOC, 0, 2);
      // free pages on both sides of the wrap only
      queue_req(pbra_pkg::OP_FREE, 4095, 1);
      queue_req(pbra_pkg::OP_FREE, 0, 1);
      queue_req(pbra_pkg::OP_ALLOC, 0, 2);
      queue_req(pbra_pkg::OP_FREE, 2730, 1365);
      queue_req(pbra_pkg::OP_FREE, 1365, 2730);
      queue_req(pbra_pkg::OP_ALLOC, 0, 4095);
      queue_req(pbra_pkg::OP_ALLOC, 0, 2731);
      wait_drained();

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         write_page_count(PHASE_PAGES[ph]);
         steady = (ph == STEADY_PHASE);
         span = (PHASE_PAGES[ph] > MAX_PAGES) ? MAX_PAGES : int'(PHASE_PAGES[ph]);
         if (span == 0) span = 1;
         for (int i = 0; i < PHASE_ITEMS[ph]; i++) begin
            reqs_waiting.push_back(random_req(span));
            reqs_queued++;
         end
         wait_drained();
      end
      steady = 1'b0;

      repeat (TAIL_CYCLES) @(negedge clock);
      if (mismatches == 0 && outcomes_due.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
